[hw/rtl/ps2h_pkg.sv]
package ps2h_pkg;

  localparam int TICK_COUNT_WIDTH = 10;
  localparam int CFG_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CMP_W = (TICK_COUNT_WIDTH > CFG_W) ? TICK_COUNT_WIDTH : CFG_W;

  localparam logic [TICK_COUNT_WIDTH-1:0] WAIT_MAX = {TICK_COUNT_WIDTH{1'b1}};

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_SEND = 2'd1;
  localparam logic [1:0] CMD_RECV = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RTS_CLOCK_HOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RTS_DATA_HOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_RELEASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RX_RELEASE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RX_START_DELAY = 3'd4;

  localparam logic [CFG_W-1:0] RST_RTS_CLOCK_HOLD = 10'd300;
  localparam logic [CFG_W-1:0] RST_RTS_DATA_HOLD  = 10'd10;
  localparam logic [CFG_W-1:0] RST_STOP_RELEASE   = 10'd50;
  localparam logic [CFG_W-1:0] RST_RX_RELEASE     = 10'd50;
  localparam logic [CFG_W-1:0] RST_RX_START_DELAY = 10'd5;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_TX_REL, PH_TX_CLKLO, PH_TX_DATALO, PH_TX_WAIT_DEV,
    PH_TX_BIT_HI, PH_TX_BIT_LO, PH_TX_PAR_HI, PH_TX_PAR_LO,
    PH_TX_STOP_DLY, PH_TX_ACK_WAIT, PH_TX_IDLE_WAIT,
    PH_RX_REL, PH_RX_WAIT_START, PH_RX_START_DLY, PH_RX_EAT_START,
    PH_RX_BIT_LO, PH_RX_BIT_HI, PH_RX_PAR_LO, PH_RX_PAR_HI,
    PH_RX_STOP_LO, PH_RX_STOP_HI
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic       clk_level;
    logic       data_level;
  } item_t;

  typedef struct packed {
    logic       clk_pull_low;
    logic       data_pull_low;
    logic [7:0] rx_data;
    logic       rx_done;
    logic       tx_done;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] rts_clock_hold_ticks;
    logic [CFG_W-1:0] rts_data_hold_ticks;
    logic [CFG_W-1:0] stop_release_ticks;
    logic [CFG_W-1:0] rx_release_ticks;
    logic [CFG_W-1:0] rx_start_delay_ticks;
  } cfg_t;

  // Delay is over once the count reaches the limit, or the counter is full.
  function automatic logic delay_done(logic [TICK_COUNT_WIDTH-1:0] count,
                                      logic [CFG_W-1:0] limit);
    return (CMP_W'(count) >= CMP_W'(limit)) || (count == WAIT_MAX);
  endfunction

endpackage

[hw/rtl/ps2h_item_if.sv]
interface ps2h_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] tx_byte;
  logic       clk_level;
  logic       data_level;

  modport source (output valid, command, tx_byte, clk_level, data_level, input ready);
  modport sink (input valid, command, tx_byte, clk_level, data_level, output ready);
endinterface

[hw/rtl/ps2h_result_if.sv]
interface ps2h_result_if;
  logic       valid;
  logic       ready;
  logic       clk_pull_low;
  logic       data_pull_low;
  logic [7:0] rx_data;
  logic       rx_done;
  logic       tx_done;
  logic       busy_res;

  modport source (output valid, clk_pull_low, data_pull_low, rx_data, rx_done, tx_done,
                  busy_res, input ready);
  modport sink (input valid, clk_pull_low, data_pull_low, rx_data, rx_done, tx_done,
                busy_res, output ready);
endinterface

[hw/rtl/ps2h_cfg_if.sv]
interface ps2h_cfg_if
  import ps2h_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/ps2h_cfg_regs.sv]
module ps2h_cfg_regs
  import ps2h_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  ps2h_cfg_if.sink cfg,
  output cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.rts_clock_hold_ticks <= RST_RTS_CLOCK_HOLD;
      regs.rts_data_hold_ticks  <= RST_RTS_DATA_HOLD;
      regs.stop_release_ticks   <= RST_STOP_RELEASE;
      regs.rx_release_ticks     <= RST_RX_RELEASE;
      regs.rx_start_delay_ticks <= RST_RX_START_DELAY;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_RTS_CLOCK_HOLD: regs.rts_clock_hold_ticks <= cfg.data;
        REG_RTS_DATA_HOLD:  regs.rts_data_hold_ticks  <= cfg.data;
        REG_STOP_RELEASE:   regs.stop_release_ticks   <= cfg.data;
        REG_RX_RELEASE:     regs.rx_release_ticks     <= cfg.data;
        REG_RX_START_DELAY: regs.rx_start_delay_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/ps2h_engine.sv]
module ps2h_engine
  import ps2h_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    regs,
  output result_t res
);

  phase_t                      phase, phase_next;
  logic [7:0]                  shifter, shifter_next;
  logic [3:0]                  bit_count, bit_count_next;
  logic                        parity_acc, parity_acc_next;
  logic [TICK_COUNT_WIDTH-1:0] wait_count, wait_count_next;
  logic                        clk_drive, clk_drive_next;
  logic                        data_drive, data_drive_next;
  logic                        rx_done, tx_done;

  // Shared delay step: either leave for nxt with a cleared count, or count on.
  logic [CFG_W-1:0] dly_limit;
  logic             dly_done;
  assign dly_done = delay_done(wait_count, dly_limit);

  always_comb begin
    unique case (phase)
      PH_TX_REL, PH_TX_CLKLO: dly_limit = regs.rts_clock_hold_ticks;
      PH_TX_DATALO:           dly_limit = regs.rts_data_hold_ticks;
      PH_TX_STOP_DLY:         dly_limit = regs.stop_release_ticks;
      PH_RX_REL:              dly_limit = regs.rx_release_ticks;
      PH_RX_START_DLY:        dly_limit = regs.rx_start_delay_ticks;
      default:                dly_limit = '0;
    endcase
  end

  always_comb begin
    logic [7:0] sh_shift;
    logic [3:0] cnt_inc;
    logic       par_new;
    sh_shift        = {1'b0, shifter[7:1]};
    cnt_inc         = bit_count + 4'd1;
    par_new         = parity_acc ^ shifter[0];
    phase_next      = phase;
    shifter_next    = shifter;
    bit_count_next  = bit_count;
    parity_acc_next = parity_acc;
    wait_count_next = wait_count;
    clk_drive_next  = clk_drive;
    data_drive_next = data_drive;
    rx_done         = 1'b0;
    tx_done         = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (item.command == CMD_SEND) begin
          shifter_next    = item.tx_byte;
          bit_count_next  = '0;
          parity_acc_next = 1'b1;
          clk_drive_next  = 1'b0;
          data_drive_next = 1'b0;
          phase_next      = PH_TX_REL;
          wait_count_next = '0;
        end else if (item.command == CMD_RECV) begin
          shifter_next    = '0;
          bit_count_next  = '0;
          clk_drive_next  = 1'b0;
          data_drive_next = 1'b0;
          phase_next      = PH_RX_REL;
          wait_count_next = '0;
        end
      end
      PH_TX_REL, PH_TX_CLKLO, PH_TX_DATALO, PH_TX_STOP_DLY, PH_RX_REL,
      PH_RX_START_DLY: begin
        if (dly_done) begin
          wait_count_next = '0;
          unique case (phase)
            PH_TX_REL: begin
              clk_drive_next = 1'b1;
              phase_next     = PH_TX_CLKLO;
            end
            PH_TX_CLKLO: begin
              data_drive_next = 1'b1;
              phase_next      = PH_TX_DATALO;
            end
            PH_TX_DATALO: begin
              clk_drive_next = 1'b0;
              phase_next     = PH_TX_WAIT_DEV;
            end
            PH_TX_STOP_DLY:  phase_next = PH_TX_ACK_WAIT;
            PH_RX_REL:       phase_next = PH_RX_WAIT_START;
            default:         phase_next = PH_RX_EAT_START;
          endcase
        end else begin
          wait_count_next = wait_count + 1'b1;
        end
      end
      PH_TX_WAIT_DEV: begin
        if (!item.clk_level) begin
          data_drive_next = ~shifter[0];
          phase_next      = PH_TX_BIT_HI;
        end
      end
      PH_TX_BIT_HI: if (item.clk_level) phase_next = PH_TX_BIT_LO;
      PH_TX_BIT_LO: begin
        if (!item.clk_level) begin
          parity_acc_next = par_new;
          shifter_next    = sh_shift;
          bit_count_next  = cnt_inc;
          if (cnt_inc >= BITS_PER_BYTE) begin
            data_drive_next = ~par_new;
            phase_next      = PH_TX_PAR_HI;
          end else begin
            data_drive_next = ~sh_shift[0];
            phase_next      = PH_TX_BIT_HI;
          end
        end
      end
      PH_TX_PAR_HI: if (item.clk_level) phase_next = PH_TX_PAR_LO;
      PH_TX_PAR_LO: begin
        if (!item.clk_level) begin
          data_drive_next = 1'b0;
          phase_next      = PH_TX_STOP_DLY;
          wait_count_next = '0;
        end
      end
      PH_TX_ACK_WAIT: if (!item.clk_level) phase_next = PH_TX_IDLE_WAIT;
      PH_TX_IDLE_WAIT: begin
        if (item.clk_level && item.data_level) begin
          clk_drive_next = 1'b1;
          tx_done        = 1'b1;
          phase_next     = PH_IDLE;
        end
      end
      PH_RX_WAIT_START: begin
        if (!item.clk_level) begin
          phase_next      = PH_RX_START_DLY;
          wait_count_next = '0;
        end
      end
      PH_RX_EAT_START: if (item.clk_level) phase_next = PH_RX_BIT_LO;
      PH_RX_BIT_LO: begin
        if (!item.clk_level) begin
          if (item.data_level) shifter_next[bit_count[2:0]] = 1'b1;
          phase_next = PH_RX_BIT_HI;
        end
      end
      PH_RX_BIT_HI: begin
        if (item.clk_level) begin
          bit_count_next = cnt_inc;
          phase_next     = (cnt_inc >= BITS_PER_BYTE) ? PH_RX_PAR_LO : PH_RX_BIT_LO;
        end
      end
      PH_RX_PAR_LO:  if (!item.clk_level) phase_next = PH_RX_PAR_HI;
      PH_RX_PAR_HI:  if (item.clk_level) phase_next = PH_RX_STOP_LO;
      PH_RX_STOP_LO: if (!item.clk_level) phase_next = PH_RX_STOP_HI;
      PH_RX_STOP_HI: begin
        if (item.clk_level) begin
          clk_drive_next = 1'b1;
          rx_done        = 1'b1;
          phase_next     = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    res.clk_pull_low  = clk_drive_next;
    res.data_pull_low = data_drive_next;
    res.rx_data       = rx_done ? shifter : 8'd0;
    res.rx_done       = rx_done;
    res.tx_done       = tx_done;
    res.busy_res      = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      shifter    <= '0;
      bit_count  <= '0;
      parity_acc <= 1'b1;
      wait_count <= '0;
      clk_drive  <= 1'b0;
      data_drive <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      shifter    <= shifter_next;
      bit_count  <= bit_count_next;
      parity_acc <= parity_acc_next;
      wait_count <= wait_count_next;
      clk_drive  <= clk_drive_next;
      data_drive <= data_drive_next;
    end
  end

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BITS_PER_BYTE)
    else $error("bit counter ran past a byte");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(wait_count) && $stable(shifter))
    else $error("engine state moved without a transaction");

  a_send_loads_byte: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_IDLE && item.command == CMD_SEND
    |=> phase == PH_TX_REL && shifter == $past(item.tx_byte))
    else $error("send did not load the byte");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step && (res.rx_done || res.tx_done) |=> phase == PH_IDLE && clk_drive)
    else $error("transfer end did not return to idle holding clock");

  a_dev_clock_starts_bits: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_TX_WAIT_DEV && !item.clk_level |=> phase == PH_TX_BIT_HI)
    else $error("device clock fall did not start the bit shift");

endmodule

[hw/rtl/ps2_host_byte_transfer.sv]
// PS/2 host byte transfer engine.
// items: one transaction per microsecond tick, carrying a command (none, send
//   tx_byte, receive) and the sampled clock and data line levels. A command is
//   taken only while idle.
// results: one transaction per item, giving the open-drain drives for both
//   lines, the received byte with rx_done, tx_done and busy_res.
// cfg: register writes by index (0..4); other indexes are dropped. Always ready.
// An accepted item is held in the input register, passes through the engine in a
//   single pass for the phase update, and its result lands in the result register.
//   Throughput: one item per cycle while results are taken.
// A stalled result holds in the output register; if the input register is empty it
//   still takes one more item, then ready drops until the result is taken.
// Reset: registers return to their default delays, engine goes idle with both
//   lines released, and no result is pending.
module ps2_host_byte_transfer
  import ps2h_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ps2h_item_if.sink     items,
  ps2h_result_if.source results,
  ps2h_cfg_if.sink      cfg
);

  cfg_t    regs;
  item_t   s1_item;
  logic    s1_valid;
  result_t res;
  result_t out_res;
  logic    out_valid;
  logic    advance;

  ps2h_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign advance     = s1_valid && (!out_valid || results.ready);
  assign items.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_item.command    <= items.command;
      s1_item.tx_byte    <= items.tx_byte;
      s1_item.clk_level  <= items.clk_level;
      s1_item.data_level <= items.data_level;
    end
  end

  ps2h_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .regs (regs),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= res;
  end

  assign results.valid         = out_valid;
  assign results.clk_pull_low  = out_res.clk_pull_low;
  assign results.data_pull_low = out_res.data_pull_low;
  assign results.rx_data       = out_res.rx_data;
  assign results.rx_done       = out_res.rx_done;
  assign results.tx_done       = out_res.tx_done;
  assign results.busy_res      = out_res.busy_res;

endmodule
